FILE: rtl/ttwt_pkg.sv
// Shared constants for the thermal threshold wait table.
package ttwt_pkg;

    // Default sizing
    localparam int SLOTS_DEF    = 16;
    localparam int TAG_BITS_DEF = 8;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int TAG_W    = 8;
    localparam int TEMP_W   = 16;
    localparam int MS_W     = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;
    localparam logic [OP_W-1:0] OP_OFF  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_QUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

    // Temperature and timeout constants
    localparam logic [TEMP_W-1:0] OFF_TEMP   = 16'd2940;
    localparam logic [TEMP_W-1:0] ALARM_LO_0 = 16'h0000;
    localparam logic [TEMP_W-1:0] ALARM_HI_0 = 16'hFFFF;
    localparam logic [MS_W-1:0]   FOREVER_MS = 32'hFFFF_FFFF;

endpackage

FILE: rtl/ttwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/thermal_threshold_wait_table_top.sv
// Top level of the thermal threshold wait table.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// operation selects add, set temperature, millisecond tick or camera off.
// Results appear on the result ports for one cycle each, marked by
// result_valid; last flags the final result of a request. The receiver
// cannot hold results off, so the block never waits on the output side.
// Sequencing: an add that completes at once or is rejected gives its result
// in the cycle after the request, with busy staying low. A queued add or a
// set temperature that reaches an alarm runs a scan: an alarm pass over
// all SLOTS entries, the queued result of an add, then a retire pass when
// any entry completes. A tick first sweeps the countdowns, then scans if
// any countdown expired. The passes are set by the single read and single
// write port of the entry RAM, one entry per cycle. Camera off and plain
// set temperature leave busy low. Reset empties the table, sets the
// temperature to 2940 and the alarms to 0 and 65535; no clearing pass is
// needed.
module thermal_threshold_wait_table_top
    import ttwt_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     operation,
    input  logic [TAG_W-1:0]    request_tag,
    input  logic [TEMP_W-1:0]   low_threshold,
    input  logic [TEMP_W-1:0]   high_threshold,
    input  logic [MS_W-1:0]     timeout_ms,
    input  logic [TEMP_W-1:0]   new_temperature,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    done_tag,
    output logic [TEMP_W-1:0]   reported_temperature,
    output logic [TEMP_W-1:0]   lower_alarm,
    output logic [TEMP_W-1:0]   upper_alarm,
    output logic                last
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TAG_CP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    // Entry layout: {tag, low, high, remaining, forever}
    localparam int E_W      = TAG_BITS + TEMP_W + TEMP_W + MS_W + 1;
    localparam int E_REM_LO = 1;
    localparam int E_HI_LO  = E_REM_LO + MS_W;
    localparam int E_LO_LO  = E_HI_LO + TEMP_W;
    localparam int E_TAG_LO = E_LO_LO + TEMP_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;
    localparam logic [2:0] ST_SCAN1 = 3'd2;
    localparam logic [2:0] ST_EMITQ = 3'd3;
    localparam logic [2:0] ST_SCAN2 = 3'd4;

    logic [2:0]          state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [TEMP_W-1:0]   temp_reg;
    logic [TEMP_W-1:0]   alarm_lo_reg;
    logic [TEMP_W-1:0]   alarm_hi_reg;
    logic [TEMP_W-1:0]   lo_acc_reg;
    logic [TEMP_W-1:0]   hi_acc_reg;
    logic                any_done_reg;
    logic [IDX_W-1:0]    last_idx_reg;
    logic                pend_q_reg;
    logic [TAG_W-1:0]    q_tag_reg;
    logic                expired_reg;

    logic                res_valid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [TAG_W-1:0]    res_tag_reg;
    logic [TEMP_W-1:0]   res_temp_reg;
    logic [TEMP_W-1:0]   res_lo_reg;
    logic [TEMP_W-1:0]   res_hi_reg;
    logic                res_last_reg;

    // RAM port signals
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [E_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [E_W-1:0]      ram_rdata;

    ttwt_ram #(
        .WIDTH (E_W),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request decode
    logic                accept;
    logic [TAG_BITS-1:0] in_tag;
    logic [TAG_W-1:0]    in_tag_out;
    logic                add_now;
    logic                full;
    logic [IDX_W-1:0]    free_idx;
    logic                set_trig;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        in_tag     = '0;
        in_tag_out = '0;
        for (int b = 0; b < TAG_CP; b++)
        begin
            in_tag[b]     = request_tag[b];
            in_tag_out[b] = request_tag[b];
        end
    end

    assign add_now = (temp_reg <= low_threshold) || (temp_reg >= high_threshold) ||
                     (timeout_ms == '0);
    assign full    = &valid_reg;
    assign set_trig = (new_temperature <= alarm_lo_reg) ||
                      (new_temperature >= alarm_hi_reg);

    // Lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Sweep position: data for entry cnt-1 arrives while cnt reads cnt
    logic                proc_on;
    logic [IDX_W-1:0]    proc_idx;
    logic                sweep_end;
    logic                ent_valid;
    logic [TAG_BITS-1:0] e_tag;
    logic [TEMP_W-1:0]   e_low;
    logic [TEMP_W-1:0]   e_high;
    logic [MS_W-1:0]     e_rem;
    logic                e_forever;
    logic                e_done;
    logic [TAG_W-1:0]    e_tag_out;

    assign proc_on   = (cnt_reg != '0);
    assign proc_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign sweep_end = (cnt_reg == CNT_W'(SLOTS));
    assign ram_raddr = cnt_reg[IDX_W-1:0];
    assign ent_valid = proc_on && valid_reg[proc_idx];

    assign e_tag     = ram_rdata[E_TAG_LO +: TAG_BITS];
    assign e_low     = ram_rdata[E_LO_LO +: TEMP_W];
    assign e_high    = ram_rdata[E_HI_LO +: TEMP_W];
    assign e_rem     = ram_rdata[E_REM_LO +: MS_W];
    assign e_forever = ram_rdata[0];
    assign e_done    = (temp_reg <= e_low) || (temp_reg >= e_high) ||
                       (!e_forever && (e_rem == '0));

    always_comb
    begin
        e_tag_out = '0;
        for (int b = 0; b < TAG_CP; b++)
        begin
            e_tag_out[b] = e_tag[b];
        end
    end

    // Alarm pass accumulators
    logic [TEMP_W-1:0] lo_acc_next;
    logic [TEMP_W-1:0] hi_acc_next;
    logic              any_done_next;
    logic [IDX_W-1:0]  last_idx_next;

    always_comb
    begin
        lo_acc_next   = lo_acc_reg;
        hi_acc_next   = hi_acc_reg;
        any_done_next = any_done_reg;
        last_idx_next = last_idx_reg;
        if (ent_valid)
        begin
            if (e_done)
            begin
                any_done_next = 1'b1;
                last_idx_next = proc_idx;
            end
            else
            begin
                if (e_low > lo_acc_reg)
                begin
                    lo_acc_next = e_low;
                end
                if (e_high < hi_acc_reg)
                begin
                    hi_acc_next = e_high;
                end
            end
        end
    end

    // Countdown decrement during the tick sweep
    logic tick_dec;

    assign tick_dec = (state_reg == ST_TICK) && ent_valid && !e_forever && (e_rem != '0);

    // RAM write: new entry on a queued add, countdown on a tick
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata = {in_tag, low_threshold, high_threshold, timeout_ms,
                     (timeout_ms == FOREVER_MS)};
        if (accept && (operation == OP_ADD) && !add_now && !full)
        begin
            ram_we = 1'b1;
        end
        else if (tick_dec)
        begin
            ram_we    = 1'b1;
            ram_waddr = proc_idx;
            ram_wdata = {e_tag, e_low, e_high, e_rem - MS_W'(1), e_forever};
        end
    end

    // Sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            temp_reg      <= OFF_TEMP;
            alarm_lo_reg  <= ALARM_LO_0;
            alarm_hi_reg  <= ALARM_HI_0;
            lo_acc_reg    <= ALARM_LO_0;
            hi_acc_reg    <= ALARM_HI_0;
            any_done_reg  <= 1'b0;
            last_idx_reg  <= '0;
            pend_q_reg    <= 1'b0;
            q_tag_reg     <= '0;
            expired_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg      <= '0;
                    lo_acc_reg   <= ALARM_LO_0;
                    hi_acc_reg   <= ALARM_HI_0;
                    any_done_reg <= 1'b0;
                    expired_reg  <= 1'b0;
                    if (accept)
                    begin
                        case (operation)
                            OP_ADD:
                            begin
                                if (add_now || full)
                                begin
                                    res_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    valid_reg[free_idx] <= 1'b1;
                                    q_tag_reg           <= in_tag_out;
                                    pend_q_reg          <= 1'b1;
                                    state_reg           <= ST_SCAN1;
                                end
                            end
                            OP_SET:
                            begin
                                temp_reg   <= new_temperature;
                                pend_q_reg <= 1'b0;
                                if (set_trig)
                                begin
                                    state_reg <= ST_SCAN1;
                                end
                            end
                            OP_TICK:
                            begin
                                state_reg <= ST_TICK;
                            end
                            OP_OFF:
                            begin
                                temp_reg <= OFF_TEMP;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_TICK:
                begin
                    if (tick_dec && (e_rem == MS_W'(1)))
                    begin
                        expired_reg <= 1'b1;
                    end
                    if (sweep_end)
                    begin
                        cnt_reg    <= '0;
                        pend_q_reg <= 1'b0;
                        if (expired_reg || (tick_dec && (e_rem == MS_W'(1))))
                        begin
                            state_reg <= ST_SCAN1;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_SCAN1:
                begin
                    lo_acc_reg   <= lo_acc_next;
                    hi_acc_reg   <= hi_acc_next;
                    any_done_reg <= any_done_next;
                    last_idx_reg <= last_idx_next;
                    if (sweep_end)
                    begin
                        cnt_reg      <= '0;
                        alarm_lo_reg <= lo_acc_next;
                        alarm_hi_reg <= hi_acc_next;
                        if (pend_q_reg)
                        begin
                            state_reg <= ST_EMITQ;
                        end
                        else if (any_done_next)
                        begin
                            state_reg <= ST_SCAN2;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_EMITQ:
                begin
                    res_valid_reg <= 1'b1;
                    pend_q_reg    <= 1'b0;
                    state_reg     <= any_done_reg ? ST_SCAN2 : ST_IDLE;
                end
                ST_SCAN2:
                begin
                    if (ent_valid && e_done)
                    begin
                        valid_reg[proc_idx] <= 1'b0;
                        res_valid_reg       <= 1'b1;
                    end
                    if (sweep_end)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                res_tag_reg  <= in_tag_out;
                res_lo_reg   <= alarm_lo_reg;
                res_hi_reg   <= alarm_hi_reg;
                res_last_reg <= 1'b1;
                if (add_now)
                begin
                    res_status_reg <= STAT_DONE;
                    res_temp_reg   <= temp_reg;
                end
                else
                begin
                    res_status_reg <= STAT_FULL;
                    res_temp_reg   <= '0;
                end
            end
            ST_EMITQ:
            begin
                res_status_reg <= STAT_QUEUED;
                res_tag_reg    <= q_tag_reg;
                res_temp_reg   <= '0;
                res_lo_reg     <= alarm_lo_reg;
                res_hi_reg     <= alarm_hi_reg;
                res_last_reg   <= !any_done_reg;
            end
            ST_SCAN2:
            begin
                res_status_reg <= STAT_DONE;
                res_tag_reg    <= e_tag_out;
                res_temp_reg   <= temp_reg;
                res_lo_reg     <= alarm_lo_reg;
                res_hi_reg     <= alarm_hi_reg;
                res_last_reg   <= (proc_idx == last_idx_reg);
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    // Port drive
    assign busy                 = (state_reg != ST_IDLE);
    assign result_valid         = res_valid_reg;
    assign status               = res_status_reg;
    assign done_tag             = res_tag_reg;
    assign reported_temperature = res_temp_reg;
    assign lower_alarm          = res_lo_reg;
    assign upper_alarm          = res_hi_reg;
    assign last                 = res_last_reg;

endmodule
